// ===== src/cpvg_pkg.sv =====
// Package for the circle polygon vertex generator.
// Holds the shared fixed-point types, constants, the CORDIC arctangent table
// and the request/response structs between the top level and the CORDIC unit.
package cpvg_pkg;

    // Request geometry.
    localparam int MAX_DIVISIONS     = 62;
    localparam int DEFAULT_DIVISIONS = 30;
    localparam int FRACTION_BITS     = 8;

    // Trig arithmetic in Q16.
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_GAIN_Q16  = 39797;
    localparam int TRIG_ONE         = 65536;
    localparam int RAD_PER_TURN_Q16 = 411775;

    // Output scaling: rim offset is (radius * trig) rounded to FRACTION_BITS.
    localparam int SCALE_SHIFT = 16 - FRACTION_BITS;
    localparam int ROUND_BIAS  = 1 << (SCALE_SHIFT - 1);

    // Trig values in Q16, clamped to [-1, 1]; CORDIC x/y fit the same width.
    typedef logic signed [17:0] trig_t;
    // CORDIC angle accumulator in radians Q16.
    typedef logic signed [18:0] angle_t;
    // Output coordinate, signed fixed point.
    typedef logic signed [24:0] coord_t;

    // Control from the sequencer to the CORDIC unit.
    typedef struct packed {
        logic   load;
        angle_t angle;
    } cordic_req_t;

    // Status and results from the CORDIC unit.
    typedef struct packed {
        logic  done;
        trig_t cos_val;
        trig_t sin_val;
    } cordic_rsp_t;

    // Arctangent of 2^-k in radians Q16, truncated.
    function automatic logic [16:0] atan_lut(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd51471;
            4'd1:    v = 17'd30385;
            4'd2:    v = 17'd16054;
            4'd3:    v = 17'd8149;
            4'd4:    v = 17'd4090;
            4'd5:    v = 17'd2047;
            4'd6:    v = 17'd1023;
            4'd7:    v = 17'd511;
            4'd8:    v = 17'd255;
            4'd9:    v = 17'd127;
            4'd10:   v = 17'd63;
            4'd11:   v = 17'd31;
            4'd12:   v = 17'd15;
            4'd13:   v = 17'd7;
            4'd14:   v = 17'd3;
            4'd15:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/cpvg_cordic.sv =====
// Iterative CORDIC rotation unit: one micro-rotation per clock cycle.
// Produces clamped Q16 cosine and sine of an angle in the first quadrant.
// Depends on cpvg_pkg for types, constants and the arctangent table.
module cpvg_cordic
    import cpvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    trig_t      x_reg;
    trig_t      y_reg;
    angle_t     z_reg;
    logic [3:0] step_reg;
    logic       run_reg;
    logic       done_reg;

    trig_t  dx;
    trig_t  dy;
    angle_t atan_k;

    // Shifted terms of the current micro-rotation (floor shifts).
    always_comb
    begin
        dx     = y_reg >>> step_reg;
        dy     = x_reg >>> step_reg;
        atan_k = angle_t'({2'b00, atan_lut(step_reg)});
    end

    // Rotation sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.load)
            begin
                x_reg    <= trig_t'(CORDIC_GAIN_Q16);
                y_reg    <= '0;
                z_reg    <= req.angle;
                step_reg <= '0;
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                if (!z_reg[18])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_k;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_k;
                end
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'(CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Clamp results to [-1, 1] in Q16.
    always_comb
    begin
        rsp.done = done_reg;
        if (x_reg > trig_t'(TRIG_ONE))
            rsp.cos_val = trig_t'(TRIG_ONE);
        else if (x_reg < -trig_t'(TRIG_ONE))
            rsp.cos_val = -trig_t'(TRIG_ONE);
        else
            rsp.cos_val = x_reg;
        if (y_reg > trig_t'(TRIG_ONE))
            rsp.sin_val = trig_t'(TRIG_ONE);
        else if (y_reg < -trig_t'(TRIG_ONE))
            rsp.sin_val = -trig_t'(TRIG_ONE);
        else
            rsp.sin_val = y_reg;
    end

endmodule

// ===== src/circle_polygon_vertex_generator.sv =====
// Top level of the circle polygon vertex generator: request sequencer,
// serial phase divider, shared multiplier and output registers.
// Depends on cpvg_pkg and the cpvg_cordic rotation unit.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+---------------------------------------------
//   request   | start / busy          | centre_x, centre_y, circle_radius,
//             |                       | division_count, fan_mode
//   vertex    | result_valid (strobe) | point_x, point_y, last_point
//
// A request of n segments yields n + 1 rim vertices, preceded by the centre in
// fan mode. The 17-step divider for the phase increment runs once per request;
// each vertex then costs one angle multiply, 16 CORDIC micro-rotations and two
// scaling multiplies on the single shared multiplier. busy is high from the
// cycle after a start transaction until the last vertex is shown. Reset clears
// the sequencer and the strobe. The receiver cannot stall: each vertex is shown
// for one cycle.
module circle_polygon_vertex_generator
    import cpvg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] centre_x,
    input  logic signed [15:0] centre_y,
    input  logic        [13:0] circle_radius,
    input  logic        [5:0]  division_count,
    input  logic               fan_mode,
    output logic               result_valid,
    output logic signed [24:0] point_x,
    output logic signed [24:0] point_y,
    output logic               last_point
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CENTRE,
        ST_ANGLE,
        ST_CORDIC,
        ST_SCALE_X,
        ST_SCALE_Y
    } state_t;

    state_t       state_reg;
    coord_t       base_x_reg;
    coord_t       base_y_reg;
    logic [13:0]  radius_reg;
    logic [5:0]   div_n_reg;
    logic         fan_reg;
    logic [4:0]   div_cnt_reg;
    logic [5:0]   div_rem_reg;
    logic [15:0]  step_q_reg;
    logic [5:0]   step_r_reg;
    logic [15:0]  phase_reg;
    logic [5:0]   phase_rem_reg;
    logic [5:0]   index_reg;
    coord_t       px_reg;

    logic [5:0]   n_eff;
    logic [6:0]   div_trial;
    logic         div_fits;
    logic [6:0]   rem_sum;
    logic         rem_wrap;
    logic         is_last;

    trig_t        rot_cos;
    trig_t        rot_sin;
    logic signed [19:0] mul_a;
    logic signed [14:0] mul_b;
    logic signed [34:0] mul_prod;
    logic signed [34:0] mul_rnd;
    logic signed [34:0] ang_rnd;
    logic signed [34-SCALE_SHIFT:0] scaled;
    coord_t       coord;
    coord_t       req_base_x;
    coord_t       req_base_y;

    cordic_req_t  cordic_req;
    cordic_rsp_t  cordic_rsp;

    assign busy = (state_reg != ST_IDLE);

    // Effective segment count of an incoming request.
    always_comb
    begin
        if (division_count == 6'd0)
            n_eff = 6'(DEFAULT_DIVISIONS);
        else if (division_count > 6'(MAX_DIVISIONS))
            n_eff = 6'(MAX_DIVISIONS);
        else
            n_eff = division_count;
        req_base_x = coord_t'(centre_x) <<< FRACTION_BITS;
        req_base_y = coord_t'(centre_y) <<< FRACTION_BITS;
    end

    // Restoring divider step for 65536 / n, and the per-vertex phase remainder.
    always_comb
    begin
        div_trial = {div_rem_reg, (div_cnt_reg == 5'd16)};
        div_fits  = (div_trial >= {1'b0, div_n_reg});
        rem_sum   = {1'b0, phase_rem_reg} + {1'b0, step_r_reg};
        rem_wrap  = (rem_sum >= {1'b0, div_n_reg});
        is_last   = (index_reg == div_n_reg);
    end

    // Quadrant rotation of the first-quadrant CORDIC result.
    always_comb
    begin
        case (phase_reg[15:14])
            2'd0:
            begin
                rot_cos = cordic_rsp.cos_val;
                rot_sin = cordic_rsp.sin_val;
            end
            2'd1:
            begin
                rot_cos = -cordic_rsp.sin_val;
                rot_sin = cordic_rsp.cos_val;
            end
            2'd2:
            begin
                rot_cos = -cordic_rsp.cos_val;
                rot_sin = -cordic_rsp.sin_val;
            end
            default:
            begin
                rot_cos = cordic_rsp.sin_val;
                rot_sin = -cordic_rsp.cos_val;
            end
        endcase
    end

    // Shared multiplier: phase to radians, then radius times cosine and sine.
    always_comb
    begin
        case (state_reg)
            ST_ANGLE:
            begin
                mul_a = 20'(RAD_PER_TURN_Q16);
                mul_b = {1'b0, phase_reg[13:0]};
            end
            ST_SCALE_X:
            begin
                mul_a = 20'(rot_cos);
                mul_b = {1'b0, radius_reg};
            end
            default:
            begin
                mul_a = 20'(rot_sin);
                mul_b = {1'b0, radius_reg};
            end
        endcase
        mul_prod = 35'(mul_a) * 35'(mul_b);
        ang_rnd  = mul_prod + 35'sd32768;
        mul_rnd  = mul_prod + 35'(ROUND_BIAS);
        scaled   = mul_rnd[34:SCALE_SHIFT];
    end

    // Vertex coordinate: centre plus rounded rim offset.
    always_comb
    begin
        if (state_reg == ST_SCALE_X)
            coord = base_x_reg + coord_t'(scaled);
        else
            coord = base_y_reg + coord_t'(scaled);
        cordic_req.load  = (state_reg == ST_ANGLE);
        cordic_req.angle = angle_t'(ang_rnd[34:16]);
    end

    cpvg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    // Sequencer, working registers and the registered vertex outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            radius_reg    <= '0;
            div_n_reg     <= '0;
            fan_reg       <= 1'b0;
            div_cnt_reg   <= '0;
            div_rem_reg   <= '0;
            step_q_reg    <= '0;
            step_r_reg    <= '0;
            phase_reg     <= '0;
            phase_rem_reg <= '0;
            index_reg     <= '0;
            px_reg        <= '0;
            result_valid  <= 1'b0;
            point_x       <= '0;
            point_y       <= '0;
            last_point    <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        base_x_reg  <= req_base_x;
                        base_y_reg  <= req_base_y;
                        radius_reg  <= circle_radius;
                        div_n_reg   <= n_eff;
                        fan_reg     <= fan_mode;
                        div_cnt_reg <= 5'd16;
                        div_rem_reg <= '0;
                        step_q_reg  <= '0;
                        state_reg   <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    // One quotient bit per cycle, most significant first.
                    if (div_fits)
                        div_rem_reg <= 6'(div_trial - {1'b0, div_n_reg});
                    else
                        div_rem_reg <= div_trial[5:0];
                    step_q_reg  <= {step_q_reg[14:0], div_fits};
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                    if (div_cnt_reg == 5'd0)
                    begin
                        if (div_fits)
                            step_r_reg <= 6'(div_trial - {1'b0, div_n_reg});
                        else
                            step_r_reg <= div_trial[5:0];
                        phase_reg     <= '0;
                        phase_rem_reg <= div_n_reg >> 1;
                        index_reg     <= '0;
                        state_reg     <= fan_reg ? ST_CENTRE : ST_ANGLE;
                    end
                end

                ST_CENTRE:
                begin
                    result_valid <= 1'b1;
                    point_x      <= base_x_reg;
                    point_y      <= base_y_reg;
                    last_point   <= 1'b0;
                    state_reg    <= ST_ANGLE;
                end

                ST_ANGLE:
                begin
                    state_reg <= ST_CORDIC;
                end

                ST_CORDIC:
                begin
                    if (cordic_rsp.done)
                        state_reg <= ST_SCALE_X;
                end

                ST_SCALE_X:
                begin
                    px_reg    <= coord;
                    state_reg <= ST_SCALE_Y;
                end

                ST_SCALE_Y:
                begin
                    result_valid <= 1'b1;
                    point_x      <= px_reg;
                    point_y      <= coord;
                    last_point   <= is_last;
                    // Advance the phase by 65536 / n with the remainder carried.
                    if (rem_wrap)
                    begin
                        phase_rem_reg <= 6'(rem_sum - {1'b0, div_n_reg});
                        phase_reg     <= phase_reg + step_q_reg + 16'd1;
                    end
                    else
                    begin
                        phase_rem_reg <= rem_sum[5:0];
                        phase_reg     <= phase_reg + step_q_reg;
                    end
                    index_reg <= index_reg + 6'd1;
                    state_reg <= is_last ? ST_IDLE : ST_ANGLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/cpvg_checker.sv =====
// Port-level checker for the circle polygon vertex generator, with its bind.
// Depends only on the top level's ports.
module cpvg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input logic               last_point
);

    // A start transaction always launches a busy interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("start transaction did not raise busy");

    // The final vertex closes the transaction in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_point |-> !busy)
        else $error("busy still high on the final vertex");

    // Every earlier vertex belongs to a running transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_point |-> busy)
        else $error("vertex shown outside a transaction");

    // Vertices are never shown in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("vertex strobe held for two cycles");

    // An idle block shows no vertex in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("vertex shown after idle cycle");

endmodule

bind circle_polygon_vertex_generator cpvg_checker u_cpvg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .last_point   (last_point)
);
